// ----- sv/bds_pkg.sv -----
package bds_pkg;

	localparam int unsigned ClockW   = 27;
	localparam int unsigned BaudW    = 23;
	localparam int unsigned DivW     = 16;
	localparam int unsigned ActualW  = 25;

	// first division: (clock / 4) / baud, the divide-by-16 quotient is that over 4
	localparam int unsigned Div1DW   = ClockW - 2;
	localparam int unsigned Div1VW   = BaudW;
	localparam int unsigned Div1SW   = 1;

	// second division: achieved rate, divisor up to 65536
	localparam int unsigned Div2DW   = ClockW - 2;
	localparam int unsigned Div2VW   = DivW + 1;
	localparam int unsigned Div2SW   = DivW + 2;

	localparam logic [ClockW-1:0] ClockReset = ClockW'(12000000);
	localparam logic [DivW-1:0]   DivMax     = '1;
	localparam int unsigned       LowMinDiv  = 10;
	localparam int unsigned       HighMinQ   = 2;
	// largest divide-by-4 divisor: quotient by 16 at most 10 gives at most 43 by 4
	localparam int unsigned       HighMaxDiv = 42;

endpackage

// ----- sv/bds_if.sv -----
interface bds_req_if;
	import bds_pkg::*;
	logic              valid;
	logic              ready;
	logic [BaudW-1:0]  requested_baud;

	modport source (output valid, output requested_baud, input ready);
	modport sink (input valid, input requested_baud, output ready);
endinterface

interface bds_res_if;
	import bds_pkg::*;
	logic                valid;
	logic                ready;
	logic [DivW-1:0]     divisor;
	logic                high_speed;
	logic                ok;
	logic [ActualW-1:0]  actual_baud;

	modport source (output valid, output divisor, output high_speed, output ok,
		output actual_baud, input ready);
	modport sink (input valid, input divisor, input high_speed, input ok,
		input actual_baud, output ready);
endinterface

// ----- sv/baud_divisor_select.sv -----
// baud_divisor_select: works out a 16-bit baud generator divisor for a
// requested baud rate from the configured input clock (clock_hz).
// req carries one requested_baud per item; res returns one item per request
// with divisor, high_speed (divide by 4 chosen), ok and actual_baud.
// cfg_we/cfg_wdata write clock_hz; write it only while no item is in flight.
// Pipeline: an accepted request passes through the
// 25 cells of the quotient divider, 25 cells of the achieved-rate divider
// and the output register. Each cell yields one quotient bit.
// Throughput: one item per cycle; the chain of cells takes a new request
// in every cycle while the output is free or being taken.
// When the receiver holds res.ready low with a result waiting, the whole
// chain freezes and req.ready drops until the result is taken.
// Reset empties the chain and sets clock_hz to 12000000.
module baud_divisor_select (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [bds_pkg::ClockW-1:0] cfg_wdata,
	bds_req_if.sink                   req,
	bds_res_if.source                 res
);
	import bds_pkg::*;

	logic [ClockW-1:0]  clock_q;
	logic               en;

	logic               v1;
	logic [Div1DW-1:0]  q4;
	logic [Div1SW-1:0]  bz1;
	logic [BaudW-1:0]   q16;

	logic               lo;
	logic               sat;
	logic               hs_ok;
	logic               ok_d;
	logic               hs_d;
	logic [DivW-1:0]    div_d;
	logic [Div2DW-1:0]  dvd2;
	logic [Div2VW-1:0]  dvs2;

	logic               v2;
	logic [Div2DW-1:0]  q2;
	logic [Div2SW-1:0]  sd2;

	logic               valid_q;
	logic [DivW-1:0]    divisor_q;
	logic               hs_q;
	logic               ok_q;
	logic [ActualW-1:0] actual_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= ClockReset;
		end else if (cfg_we) begin
			clock_q <= cfg_wdata;
		end
	end

	assign en        = ~valid_q | res.ready;
	assign req.ready = en;

	bds_divider #(.DW(Div1DW), .VW(Div1VW), .SW(Div1SW)) u_div1 (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.valid_i    (req.valid),
		.dividend_i (clock_q[ClockW-1:2]),
		.divisor_i  (req.requested_baud),
		.side_i     (req.requested_baud == '0),
		.valid_o    (v1),
		.quot_o     (q4),
		.side_o     (bz1)
	);

	// choose prescaler and set up the achieved-rate division
	always_comb begin
		q16   = q4[Div1DW-1:2];
		lo    = q16 > BaudW'(LowMinDiv);
		sat   = q16 > BaudW'({1'b1, {DivW{1'b0}}});
		hs_ok = q4 >= Div1DW'(HighMinQ);
		ok_d  = ~bz1[0] & (lo | hs_ok);
		hs_d  = ~bz1[0] & ~lo & hs_ok;
		if (lo) begin
			div_d = sat ? DivMax : DivW'(q16 - BaudW'(1));
		end else begin
			div_d = q4[DivW-1:0] - DivW'(1);
		end
		dvd2 = hs_d ? clock_q[ClockW-1:2] : {2'b00, clock_q[ClockW-1:4]};
		if (!ok_d) begin
			dvs2 = Div2VW'(1);
		end else if (sat && lo) begin
			dvs2 = {1'b1, {DivW{1'b0}}};
		end else if (hs_d) begin
			dvs2 = q4[Div2VW-1:0];
		end else begin
			dvs2 = q16[Div2VW-1:0];
		end
	end

	bds_divider #(.DW(Div2DW), .VW(Div2VW), .SW(Div2SW)) u_div2 (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.valid_i    (v1),
		.dividend_i (dvd2),
		.divisor_i  (dvs2),
		.side_i     ({ok_d, hs_d, div_d}),
		.valid_o    (v2),
		.quot_o     (q2),
		.side_o     (sd2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= v2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_q      <= sd2[DivW+1];
			hs_q      <= sd2[DivW+1] & sd2[DivW];
			divisor_q <= sd2[DivW+1] ? sd2[DivW-1:0] : '0;
			actual_q  <= sd2[DivW+1] ? ActualW'(q2) : '0;
		end
	end

	assign res.valid       = valid_q;
	assign res.divisor     = divisor_q;
	assign res.high_speed  = hs_q;
	assign res.ok          = ok_q;
	assign res.actual_baud = actual_q;

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ok) |-> (res.divisor == '0 && res.actual_baud == '0 && !res.high_speed))
		else $error("failed item carries non-zero fields");

	a_hs_range: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.high_speed) |-> (res.ok && res.divisor >= DivW'(1)
			&& res.divisor <= DivW'(HighMaxDiv)))
		else $error("divide-by-4 divisor out of range");

	a_lo_range: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.ok && !res.high_speed) |-> (res.divisor >= DivW'(LowMinDiv)))
		else $error("divide-by-16 divisor below minimum");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |-> (!req.ready ##1 $stable(res.actual_baud)))
		else $error("chain moved while output stalled");

endmodule

// ----- sv/bds_div_cell.sv -----
module bds_div_cell #(
	parameter int unsigned DW = 25,
	parameter int unsigned VW = 23,
	parameter int unsigned SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          valid_i,
	input  logic [VW-1:0] rem_i,
	input  logic [DW-1:0] dq_i,
	input  logic [VW-1:0] dvs_i,
	input  logic [SW-1:0] side_i,
	output logic          valid_o,
	output logic [VW-1:0] rem_o,
	output logic [DW-1:0] dq_o,
	output logic [VW-1:0] dvs_o,
	output logic [SW-1:0] side_o
);

	logic [VW:0]   shifted;
	logic [VW+1:0] diff;
	logic          bit_q;
	logic [VW-1:0] rem_d;

	// restoring step: bring down the next dividend bit, subtract if it fits
	always_comb begin
		shifted = {rem_i, dq_i[DW-1]};
		diff    = {1'b0, shifted} - {2'b00, dvs_i};
		bit_q   = ~diff[VW+1];
		rem_d   = bit_q ? diff[VW-1:0] : shifted[VW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o  <= rem_d;
			dq_o   <= {dq_i[DW-2:0], bit_q};
			dvs_o  <= dvs_i;
			side_o <= side_i;
		end
	end

endmodule

// ----- sv/bds_divider.sv -----
module bds_divider #(
	parameter int unsigned DW = 25,
	parameter int unsigned VW = 23,
	parameter int unsigned SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          valid_i,
	input  logic [DW-1:0] dividend_i,
	input  logic [VW-1:0] divisor_i,
	input  logic [SW-1:0] side_i,
	output logic          valid_o,
	output logic [DW-1:0] quot_o,
	output logic [SW-1:0] side_o
);

	logic          v_c   [DW+1];
	logic [VW-1:0] rem_c [DW+1];
	logic [DW-1:0] dq_c  [DW+1];
	logic [VW-1:0] dvs_c [DW+1];
	logic [SW-1:0] sd_c  [DW+1];

	assign v_c[0]   = valid_i;
	assign rem_c[0] = '0;
	assign dq_c[0]  = dividend_i;
	assign dvs_c[0] = divisor_i;
	assign sd_c[0]  = side_i;

	// one quotient bit per cell, dividend bits shift out as quotient bits shift in
	for (genvar k = 0; k < DW; k++) begin : g_cell
		bds_div_cell #(.DW(DW), .VW(VW), .SW(SW)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (v_c[k]),
			.rem_i   (rem_c[k]),
			.dq_i    (dq_c[k]),
			.dvs_i   (dvs_c[k]),
			.side_i  (sd_c[k]),
			.valid_o (v_c[k+1]),
			.rem_o   (rem_c[k+1]),
			.dq_o    (dq_c[k+1]),
			.dvs_o   (dvs_c[k+1]),
			.side_o  (sd_c[k+1])
		);
	end

	assign valid_o = v_c[DW];
	assign quot_o  = dq_c[DW];
	assign side_o  = sd_c[DW];

endmodule

// ----- verif/tb_baud_divisor_select.sv -----
`timescale 1ns / 100ps

module tb_baud_divisor_select;
	import bds_pkg::*;

	typedef struct packed {
		logic [DivW-1:0]    divisor;
		logic               high_speed;
		logic               ok;
		logic [ActualW-1:0] actual_baud;
	} rate_t;

	typedef struct {
		logic [ClockW-1:0] clk_hz;
		logic              wr;
		logic [BaudW-1:0]  baud;
		logic              typed;
		rate_t             want;
	} row_t;

	localparam int unsigned StallLimit = 5000;
	localparam int unsigned Latency = 51;
	localparam int unsigned NumRandom = 1950;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ClockW-1:0] cfg_wdata;

	bds_req_if req ();
	bds_res_if res ();

	baud_divisor_select u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req.sink),
		.res      (res.source)
	);

	logic [ClockW-1:0] model_clock_hz;
	rate_t rates_due[$];
	int errors;
	int idle_cycles;
	bit quiet;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic rate_t pick_divisor(logic [ClockW-1:0] hz, logic [BaudW-1:0] baud);
		rate_t r;
		longint unsigned q;
		longint unsigned d;
		longint unsigned pre;
		r = '0;
		d = 0;
		pre = 16;
		if (baud != 0) begin
			q = longint'(hz) / (longint'(baud) * 16);
			if (q > LowMinDiv) begin
				d = (q > 65536) ? 65535 : q - 1;
				r.ok = 1'b1;
			end else begin
				q = longint'(hz) / (longint'(baud) * 4);
				if (q >= HighMinQ) begin
					d = q - 1;
					pre = 4;
					r.high_speed = 1'b1;
					r.ok = 1'b1;
				end
			end
		end
		if (r.ok) begin
			r.divisor = DivW'(d);
			r.actual_baud = ActualW'(longint'(hz) / (pre * (d + 1)));
		end
		return r;
	endfunction

	// output side: random stalls, compare each item with the oldest prediction
	initial begin
		int gap;
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 9) == 0) begin
				gap = $urandom_range(1, 19);
				res.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			res.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		rate_t got;
		rate_t exp_r;
		if (arst_n && res.valid && res.ready) begin
			got = '{res.divisor, res.high_speed, res.ok, res.actual_baud};
			if (rates_due.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
			end else begin
				exp_r = rates_due.pop_front();
				if (got !== exp_r) begin
					$display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
					errors++;
				end
			end
		end
	end

	// watchdog over cycles with no item moving on either side
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (res.valid && res.ready))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= StallLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_baud(logic [BaudW-1:0] baud, bit typed, rate_t want);
		rate_t pred;
		pred = pick_divisor(model_clock_hz, baud);
		if (typed && pred !== want) begin
			$display("%0t: table row expected %p actual %p", $time, want, pred);
			errors++;
		end
		req.valid <= 1'b1;
		req.requested_baud <= baud;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		rates_due.push_back(pred);
		@(negedge clk);
	endtask

	task automatic hold_off();
		req.valid <= 1'b0;
		repeat ($urandom_range(1, 19)) @(negedge clk);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (rates_due.size() != 0)
			@(negedge clk);
		repeat (Latency + 5) @(negedge clk);
	endtask

	task automatic set_clock(logic [ClockW-1:0] hz);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= hz;
		@(negedge clk);
		cfg_we <= 1'b0;
		model_clock_hz = hz;
	endtask

	function automatic logic [BaudW-1:0] rand_baud();
		case ($urandom_range(0, 5))
			0: return BaudW'($urandom_range(1, 6250000));
			1: return BaudW'($urandom);
			2: return BaudW'($urandom_range(1, 300));
			3: return BaudW'(model_clock_hz / (16 * $urandom_range(1, 70000) + 1));
			4: return BaudW'(model_clock_hz / (4 * $urandom_range(1, 12)));
			default: return BaudW'($urandom_range(0, 3));
		endcase
	endfunction

	row_t rows[$];
	logic [ClockW-1:0] clocks[] = '{27'd1, 27'd100000000, 27'h7FFFFFF, 27'd0,
		27'd1843200, 27'd48000000, 27'd12000000};

	initial begin
		rate_t none;
		none = '0;
		errors = 0;
		idle_cycles = 0;
		quiet = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req.valid = 1'b0;
		req.requested_baud = '0;
		model_clock_hz = ClockReset;

		// directed table: reset clock first, then the extremes of the clock
		rows.push_back('{0, 0, 23'd0, 1, none});
		rows.push_back('{0, 0, 23'd9600, 1, '{16'd77, 1'b0, 1'b1, 25'd9615}});
		rows.push_back('{0, 0, 23'd1, 1, '{16'd65535, 1'b0, 1'b1, 25'd11}});
		rows.push_back('{0, 0, 23'd6250000, 1, none});
		rows.push_back('{0, 0, 23'h7FFFFF, 1, none});
		rows.push_back('{0, 0, 23'd115200, 0, none});
		rows.push_back('{0, 0, 23'd1000000, 0, none});
		rows.push_back('{0, 0, 23'd1500000, 1, '{16'd1, 1'b1, 1'b1, 25'd1500000}});
		rows.push_back('{27'd1, 1, 23'd1, 1, none});
		rows.push_back('{27'd100000000, 1, 23'd1, 1, '{16'd65535, 1'b0, 1'b1, 25'd95}});
		rows.push_back('{0, 0, 23'd6250000, 0, none});
		rows.push_back('{0, 0, 23'd6250001, 0, none});
		rows.push_back('{0, 0, 23'd600000, 0, none});
		rows.push_back('{27'h7FFFFFF, 1, 23'h7FFFFF, 0, none});
		rows.push_back('{0, 0, 23'd1, 0, none});
		rows.push_back('{27'd0, 1, 23'd9600, 1, none});
		rows.push_back('{0, 0, 23'h555555, 0, none});
		rows.push_back('{0, 0, 23'h2AAAAA, 0, none});

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			if (rows[i].wr)
				set_clock(rows[i].clk_hz);
			send_baud(rows[i].baud, rows[i].typed, rows[i].want);
		end

		for (int n = 0; n < NumRandom; n++) begin
			if (n % 250 == 0)
				set_clock((n / 250) < clocks.size() ? clocks[n / 250]
					: ClockW'($urandom_range(1, 100000000)));
			if (n == 900)
				drain();
			if (n == NumRandom - 200)
				quiet = 1;
			if (!quiet && $urandom_range(0, 9) == 0)
				hold_off();
			send_baud(rand_baud(), 0, none);
		end
		req.valid <= 1'b0;
		while (rates_due.size() != 0)
			@(negedge clk);
		repeat (Latency + 10) @(negedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
